### src/mptw_pkg.sv
package mptw_pkg;

   localparam int MAX_STATES_DEFAULT = 64;

   localparam int KEY_W   = 8;
   localparam int SCORE_W = 8;
   localparam int VALUE_W = 24;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [INDEX_W-1:0]   entry_index;
      logic [KEY_W-1:0]     window_low;
      logic [KEY_W-1:0]     window_high;
      logic [SCORE_W-1:0]   entry_score;
      logic [KEY_W-1:0]     step_key;
      logic                 first_step;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   best_total;
      logic                 feasible;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   state_count;
   } csr_payload_type;

   // Token that travels around the ring of cells.
   typedef struct packed {
      logic [SCORE_W-1:0]   score;
      logic [VALUE_W-1:0]   value;
      logic                 reach;
   } tok_type;

   // Control and shared data broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                 wr;
      logic                 start;
      logic                 run;
      logic                 commit;
      logic                 drain;
      logic                 first_step;
      logic [INDEX_W-1:0]   entry_index;
      logic [KEY_W-1:0]     window_low;
      logic [KEY_W-1:0]     window_high;
      logic [SCORE_W-1:0]   entry_score;
      logic [KEY_W-1:0]     step_key;
      logic [COUNT_W-1:0]   state_count;
   } cell_bus_type;

endpackage

### src/mptw_chan_if.sv
interface mptw_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/mptw_cell.sv
module mptw_cell
   import mptw_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_bus_type bus,
   input  tok_type      tok_prev,
   output tok_type      tok_out
);

   logic [KEY_W-1:0]   wl_ff;
   logic [KEY_W-1:0]   wh_ff;
   logic [SCORE_W-1:0] sc_ff;
   logic [VALUE_W-1:0] val_ff;
   logic               reach_ff;
   logic               elig_ff;
   logic [VALUE_W-1:0] acc_ff;
   logic               accv_ff;
   tok_type            tok_ff;

   logic               hit;
   logic               in_use;
   logic [SCORE_W-1:0] diff;
   logic [VALUE_W:0]   sum_wide;
   logic [VALUE_W-1:0] sum_sat;
   logic               nreach_in;
   logic [VALUE_W-1:0] nval_in;

   assign hit    = (32'(bus.entry_index) == INDEX);
   assign in_use = (32'(bus.state_count) > INDEX);

   always_comb begin
      diff     = (sc_ff > tok_ff.score) ? (sc_ff - tok_ff.score) : (tok_ff.score - sc_ff);
      sum_wide = {1'b0, tok_ff.value} + {{(VALUE_W + 1 - SCORE_W){1'b0}}, diff};
      // A carry out of the value width means the total is clipped at full scale.
      sum_sat  = sum_wide[VALUE_W] ? {VALUE_W{1'b1}} : sum_wide[VALUE_W-1:0];
      nreach_in = elig_ff & (bus.first_step | accv_ff);
      nval_in   = (elig_ff & ~bus.first_step & accv_ff) ? acc_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (bus.wr && hit) begin
         wl_ff <= bus.window_low;
         wh_ff <= bus.window_high;
         sc_ff <= bus.entry_score;
      end

      if (bus.start) begin
         elig_ff      <= in_use && (wl_ff <= bus.step_key) && (bus.step_key <= wh_ff);
         tok_ff.score <= sc_ff;
         tok_ff.value <= val_ff;
         tok_ff.reach <= reach_ff & in_use;
         acc_ff       <= '0;
         accv_ff      <= 1'b0;
      end else if (bus.run) begin
         tok_ff <= tok_prev;
         if (tok_ff.reach) begin
            if (!accv_ff || (sum_sat > acc_ff)) begin
               acc_ff <= sum_sat;
            end
            accv_ff <= 1'b1;
         end
      end else if (bus.commit) begin
         val_ff       <= nval_in;
         tok_ff.value <= nval_in;
         tok_ff.reach <= nreach_in;
      end else if (bus.drain) begin
         tok_ff <= tok_prev;
      end

      if (reset) begin
         reach_ff <= 1'b0;
      end else if (bus.commit) begin
         reach_ff <= nreach_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

### src/max_plus_trellis_with_windows.sv
// Max-plus trellis over a table of up to MAX_STATES states, one state per cell in
// a ring. A load item writes one table entry and gives no result.
// A step item gives one result, formed in these steps: S_START tests every window
// against the key, S_RUN circulates the previous values once around the ring so
// that each cell sees every predecessor, S_COMMIT commits the new values, and
// S_DRAIN circulates the new values again past the collector that forms the best
// total. The next item is taken once the result is in the output register. The
// state_count register is written through the csr channel, which is always ready.
module max_plus_trellis_with_windows
   import mptw_pkg::*;
#(
   parameter int MAX_STATES = MAX_STATES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mptw_chan_if.sink   req_chan,
   mptw_chan_if.source rsp_chan,
   mptw_chan_if.sink   csr_chan
);

   localparam int CNT_W = $clog2(MAX_STATES);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_START  = 6'b000010,
      S_RUN    = 6'b000100,
      S_COMMIT = 6'b001000,
      S_DRAIN  = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [COUNT_W-1:0] state_count_ff;
   logic [KEY_W-1:0]   key_ff;
   logic               first_ff;
   logic [VALUE_W-1:0] best_ff;
   logic               any_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;

   logic               req_fire;
   logic               cnt_last;
   cell_bus_type       bus;
   tok_type            tok_arr [MAX_STATES];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign cnt_last       = (cnt_ff == CNT_W'(MAX_STATES - 1));

   always_comb begin
      bus.wr          = req_fire && (req_chan.payload.cmd == CMD_LOAD);
      bus.start       = (state_ff == S_START);
      bus.run         = (state_ff == S_RUN);
      bus.commit      = (state_ff == S_COMMIT);
      bus.drain       = (state_ff == S_DRAIN);
      bus.first_step  = first_ff;
      bus.entry_index = req_chan.payload.entry_index;
      bus.window_low  = req_chan.payload.window_low;
      bus.window_high = req_chan.payload.window_high;
      bus.entry_score = req_chan.payload.entry_score;
      bus.step_key    = key_ff;
      bus.state_count = state_count_ff;
   end

   for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
      localparam int PREV = (i == 0) ? MAX_STATES - 1 : i - 1;
      mptw_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .bus      (bus),
         .tok_prev (tok_arr[PREV]),
         .tok_out  (tok_arr[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         state_count_ff <= COUNT_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            state_count_ff <= csr_chan.payload.state_count;
         end
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_chan.payload.cmd == CMD_STEP)) begin
                  state_ff <= S_START;
               end
            end
            S_START: begin
               cnt_ff   <= '0;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_last) begin
                  state_ff <= S_COMMIT;
               end
            end
            S_COMMIT: begin
               cnt_ff   <= '0;
               state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_last) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // Wait until the output register is free before placing the result.
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff   <= req_chan.payload.step_key;
         first_ff <= req_chan.payload.first_step;
      end

      if (state_ff == S_COMMIT) begin
         best_ff <= '0;
         any_ff  <= 1'b0;
      end else if (state_ff == S_DRAIN) begin
         // Every token passes the last cell once during the drain pass.
         if (tok_arr[MAX_STATES-1].reach) begin
            any_ff <= 1'b1;
            if (tok_arr[MAX_STATES-1].value > best_ff) begin
               best_ff <= tok_arr[MAX_STATES-1].value;
            end
         end
      end

      if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_payload_ff.best_total <= best_ff;
         rsp_payload_ff.feasible   <= any_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule
